[rtl/mhpq_pkg.sv]
package mhpq_pkg;

    // Operation codes carried in the op field of a request beat.
    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_REMOVE = 1'b1;

    // Status codes returned with every result beat.
    localparam int unsigned STATUS_W = 2;
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd2;

    // Fixed width of the key fields on the ports.
    localparam int unsigned PORT_KEY_W = 32;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_UP_CHK,
        S_UP_CMP,
        S_DN_LOAD,
        S_DN_CHK,
        S_DN_CMP,
        S_DONE
    } t_state;

endpackage

[rtl/mhpq_if.sv]
// Request channel: one operation per beat.
interface mhpq_req_if;
    logic                                   valid;
    logic                                   ready;
    logic                                   op;
    logic signed [mhpq_pkg::PORT_KEY_W-1:0] value;

    modport source (output valid, output op, output value, input ready);
    modport sink   (input valid, input op, input value, output ready);
endinterface

// Result channel: one result per request.
interface mhpq_rsp_if #(
    parameter int CNT_W = 7
);
    logic                                   valid;
    logic                                   ready;
    logic [mhpq_pkg::STATUS_W-1:0]          status;
    logic signed [mhpq_pkg::PORT_KEY_W-1:0] removed_max;
    logic [CNT_W-1:0]                       count;

    modport source (output valid, output status, output removed_max, output count,
                    input ready);
    modport sink   (input valid, input status, input removed_max, input count,
                    output ready);
endinterface

[rtl/max_heap_priority_queue.sv]
// Channel  | Dir | Handshake     | Payload
// i_req    | in  | valid / ready | op (0 insert, 1 remove max), value (32b signed)
// o_rsp    | out | valid / ready | status (2b), removed_max (32b signed), count
//
// One request is worked on at a time. An insert sifts the new key up from the last slot.
// A remove reads the root and the last key, then sifts that key down from the root unless
// the heap is left empty. The key moves at most 6 tree levels at the default capacity.
// Each level takes a read of the heap RAM followed by a compare / write-back.
// Error cases (insert on full, remove on empty) go straight to the result.
// Reset (synchronous, active low) empties the heap; the RAM itself is not cleared.
// A new request is taken while a finished result still waits in the output register;
// only the next result stalls behind an unconsumed beat.
module max_heap_priority_queue #(
    parameter int CAPACITY  = 127,
    parameter int KEY_WIDTH = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mhpq_req_if.sink   i_req,
    mhpq_rsp_if.source o_rsp
);

    localparam int IDX_W = $clog2(CAPACITY + 1);
    localparam int KW    = (KEY_WIDTH < 32) ? KEY_WIDTH : 32;

    // Heap RAM, slot 0 unused, root in slot 1.
    logic signed [KW-1:0] r_mem [0:CAPACITY];
    logic signed [KW-1:0] r_rd0;
    logic signed [KW-1:0] r_rd1;
    logic                 mem_we;
    logic [IDX_W-1:0]     mem_waddr;
    logic signed [KW-1:0] mem_wdata;
    logic [IDX_W-1:0]     mem_ra0;
    logic [IDX_W-1:0]     mem_ra1;

    // Control and working registers.
    mhpq_pkg::t_state               r_state, n_state;
    logic [IDX_W-1:0]               r_count, n_count;
    logic [IDX_W-1:0]               r_i, n_i;
    logic signed [KW-1:0]           r_key, n_key;
    logic signed [KW-1:0]           r_removed, n_removed;
    logic [mhpq_pkg::STATUS_W-1:0]  r_status, n_status;

    // Output register.
    logic                                   r_out_valid, n_out_valid;
    logic [mhpq_pkg::STATUS_W-1:0]          r_out_status, n_out_status;
    logic signed [mhpq_pkg::PORT_KEY_W-1:0] r_out_removed, n_out_removed;
    logic [IDX_W-1:0]                       r_out_count, n_out_count;

    // Child indexes of the current slot, one bit wider than a slot index.
    logic [IDX_W:0] left_idx;
    logic [IDX_W:0] right_idx;
    logic [IDX_W:0] count_ext;
    logic           right_ok;
    logic           pick_right;

    assign left_idx  = {r_i, 1'b0};
    assign right_idx = {r_i, 1'b1};
    assign count_ext = {1'b0, r_count};
    assign right_ok  = (right_idx <= count_ext);
    assign pick_right = right_ok && (r_rd1 > r_rd0);

    // The RAM: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= mem_wdata;
        end
        r_rd0 <= r_mem[mem_ra0];
        r_rd1 <= r_mem[mem_ra1];
    end

    // Sequencer: next state, RAM accesses and result capture.
    always_comb begin
        n_state       = r_state;
        n_count       = r_count;
        n_i           = r_i;
        n_key         = r_key;
        n_removed     = r_removed;
        n_status      = r_status;
        n_out_valid   = r_out_valid && !o_rsp.ready;
        n_out_status  = r_out_status;
        n_out_removed = r_out_removed;
        n_out_count   = r_out_count;
        mem_we        = 1'b0;
        mem_waddr     = r_i;
        mem_wdata     = r_key;
        mem_ra0       = r_i;
        mem_ra1       = r_i;
        i_req.ready   = (r_state == mhpq_pkg::S_IDLE);

        case (r_state)
            mhpq_pkg::S_IDLE: begin
                if (i_req.valid) begin
                    n_status  = mhpq_pkg::ST_OK;
                    n_removed = '0;
                    if (i_req.op == mhpq_pkg::OP_INSERT) begin
                        if (r_count >= IDX_W'(CAPACITY)) begin
                            n_status = mhpq_pkg::ST_FULL;
                            n_state  = mhpq_pkg::S_DONE;
                        end else begin
                            n_count = r_count + 1'b1;
                            n_i     = r_count + 1'b1;
                            n_key   = i_req.value[KW-1:0];
                            n_state = mhpq_pkg::S_UP_CHK;
                        end
                    end else begin
                        if (r_count == '0) begin
                            n_status = mhpq_pkg::ST_EMPTY;
                            n_state  = mhpq_pkg::S_DONE;
                        end else begin
                            // Fetch the root and the last key together.
                            mem_ra0 = IDX_W'(1);
                            mem_ra1 = r_count;
                            n_count = r_count - 1'b1;
                            n_state = mhpq_pkg::S_DN_LOAD;
                        end
                    end
                end
            end

            mhpq_pkg::S_UP_CHK: begin
                if (r_i == IDX_W'(1)) begin
                    mem_we  = 1'b1;
                    n_state = mhpq_pkg::S_DONE;
                end else begin
                    mem_ra0 = r_i >> 1;
                    n_state = mhpq_pkg::S_UP_CMP;
                end
            end

            mhpq_pkg::S_UP_CMP: begin
                // Parent smaller: move it down and climb one level.
                mem_we = 1'b1;
                if (r_rd0 < r_key) begin
                    mem_wdata = r_rd0;
                    n_i       = r_i >> 1;
                    n_state   = mhpq_pkg::S_UP_CHK;
                end else begin
                    n_state = mhpq_pkg::S_DONE;
                end
            end

            mhpq_pkg::S_DN_LOAD: begin
                n_removed = r_rd0;
                n_key     = r_rd1;
                n_i       = IDX_W'(1);
                if (r_count == '0) begin
                    n_state = mhpq_pkg::S_DONE;
                end else begin
                    n_state = mhpq_pkg::S_DN_CHK;
                end
            end

            mhpq_pkg::S_DN_CHK: begin
                if (left_idx > count_ext) begin
                    mem_we  = 1'b1;
                    n_state = mhpq_pkg::S_DONE;
                end else begin
                    mem_ra0 = left_idx[IDX_W-1:0];
                    mem_ra1 = right_ok ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
                    n_state = mhpq_pkg::S_DN_CMP;
                end
            end

            mhpq_pkg::S_DN_CMP: begin
                // Larger child above the key: move it up and descend.
                mem_we = 1'b1;
                if ((pick_right ? r_rd1 : r_rd0) > r_key) begin
                    mem_wdata = pick_right ? r_rd1 : r_rd0;
                    n_i       = pick_right ? right_idx[IDX_W-1:0] : left_idx[IDX_W-1:0];
                    n_state   = mhpq_pkg::S_DN_CHK;
                end else begin
                    n_state = mhpq_pkg::S_DONE;
                end
            end

            mhpq_pkg::S_DONE: begin
                if (!r_out_valid || o_rsp.ready) begin
                    n_out_valid   = 1'b1;
                    n_out_status  = r_status;
                    n_out_removed = mhpq_pkg::PORT_KEY_W'(r_removed);
                    n_out_count   = r_count;
                    n_state       = mhpq_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = mhpq_pkg::S_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= mhpq_pkg::S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    // Working and result payload registers.
    always_ff @(posedge i_clk) begin
        r_i           <= n_i;
        r_key         <= n_key;
        r_removed     <= n_removed;
        r_status      <= n_status;
        r_out_status  <= n_out_status;
        r_out_removed <= n_out_removed;
        r_out_count   <= n_out_count;
    end

    assign o_rsp.valid       = r_out_valid;
    assign o_rsp.status      = r_out_status;
    assign o_rsp.removed_max = r_out_removed;
    assign o_rsp.count       = r_out_count;

    // The fill count never passes the capacity.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IDX_W'(CAPACITY))
        else $error("heap count above capacity");

    // A full report only comes from a full heap.
    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == mhpq_pkg::ST_FULL)
            |-> (o_rsp.count == IDX_W'(CAPACITY)))
        else $error("full status with spare room");

    // An empty report leaves nothing held and returns no key.
    a_empty_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_rsp.valid && o_rsp.status == mhpq_pkg::ST_EMPTY)
            |-> (o_rsp.count == '0 && o_rsp.removed_max == '0))
        else $error("empty status with data");

    // Every accepted request starts work before the next one may enter.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (r_state != mhpq_pkg::S_IDLE))
        else $error("request accepted without leaving idle");

    // The sift walks only over valid slots.
    a_slot_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mhpq_pkg::S_DN_CHK || r_state == mhpq_pkg::S_UP_CHK)
            |-> (r_i != '0 && r_i <= r_count))
        else $error("sift index outside the heap");

endmodule
